@@ hw/rtl/xml_entity_decoder_macros.svh @@
// Assertion macros for the XML entity decoder.
`ifndef XML_ENTITY_DECODER_MACROS_SVH
`define XML_ENTITY_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define XED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xml_entity_decoder: same-cycle check failed");
`define XED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xml_entity_decoder: next-cycle check failed");
`else
`define XED_ASSERT_SAME(label, ante, cons)
`define XED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/xed_pkg.sv @@
// Shared constants, types and the entity match function of the XML entity decoder.
`default_nettype none
package xed_pkg;
    localparam int TOKEN_MAX   = 7;
    localparam int LENGTH_BITS = 16;
    localparam int CNT_W       = $clog2(TOKEN_MAX + 1);
    localparam int IDX_W       = $clog2(TOKEN_MAX);
    localparam int NUM_ENT     = 5;
    localparam int ENT_MAX     = 6;

    localparam logic [7:0] AMP  = 8'h26;
    localparam logic [7:0] SEMI = 8'h3B;

    typedef logic [7:0]                   byte_t;
    typedef logic [TOKEN_MAX-1:0][7:0]    tok_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [LENGTH_BITS-1:0]       len_t;

    // One accepted request turned into the bytes it releases.
    typedef struct packed {
        tok_t bytes;
        cnt_t cnt;
        logic last;
    } job_t;

    typedef struct packed {
        logic  hit;
        byte_t ch;
    } match_t;

    localparam byte_t ENT_TEXT [NUM_ENT][ENT_MAX] = '{
        '{AMP, "l", "t", SEMI, 8'h00, 8'h00},
        '{AMP, "g", "t", SEMI, 8'h00, 8'h00},
        '{AMP, "a", "m", "p", SEMI, 8'h00},
        '{AMP, "a", "p", "o", "s", SEMI},
        '{AMP, "q", "u", "o", "t", SEMI}
    };
    localparam cnt_t ENT_LEN [NUM_ENT] = '{
        cnt_t'(4), cnt_t'(4), cnt_t'(5), cnt_t'(6), cnt_t'(6)
    };
    localparam byte_t ENT_CHAR [NUM_ENT] = '{"<", ">", AMP, 8'h27, 8'h22};

    function automatic match_t ent_match(input tok_t tok, input cnt_t fill);
        match_t m;
        logic   ok;
        m = '0;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            ok = (ENT_LEN[e] == fill);
            for (int i = 0; i < ENT_MAX; i++)
            begin
                if ((cnt_t'(i) < ENT_LEN[e]) && (tok[i] != ENT_TEXT[e][i]))
                    ok = 1'b0;
            end
            if (ok)
            begin
                m.hit = 1'b1;
                m.ch  = ENT_CHAR[e];
            end
        end
        return m;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/xed_collector.sv @@
// Token collector: tracks the open entity token and registers one job per request.
`default_nettype none
module xed_collector (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire xed_pkg::byte_t text_byte,
    input  wire logic          text_last,
    output logic               job_valid,
    output xed_pkg::job_t      job,
    input  wire logic          job_take
);
    import xed_pkg::*;

    logic   in_token_reg, in_token_next;
    cnt_t   fill_reg, fill_next;
    tok_t   tok_reg, tok_next;
    logic   job_valid_reg;
    job_t   job_reg, job_next;
    tok_t   tok_app;
    cnt_t   fill_app;
    match_t m;
    logic   accept;

    assign in_ready  = !job_valid_reg || job_take;
    assign accept    = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        for (int i = 0; i < TOKEN_MAX; i++)
            tok_app[i] = (cnt_t'(i) == fill_reg) ? text_byte : tok_reg[i];
        fill_app = fill_reg + 1'b1;
        m        = ent_match(tok_app, fill_app);

        in_token_next  = in_token_reg;
        fill_next      = fill_reg;
        tok_next       = tok_reg;
        job_next       = '0;
        job_next.last  = text_last;
        job_next.bytes = tok_app;

        if (!in_token_reg)
        begin
            job_next.bytes[0] = text_byte;
            if (text_byte == AMP && !text_last)
            begin
                in_token_next = 1'b1;
                tok_next[0]   = text_byte;
                fill_next     = cnt_t'(1);
            end
            else
            begin
                job_next.cnt = cnt_t'(1);
            end
        end
        else
        begin
            tok_next  = tok_app;
            fill_next = fill_app;
            if (text_byte == SEMI || fill_app == cnt_t'(TOKEN_MAX))
            begin
                if (m.hit)
                begin
                    job_next.bytes[0] = m.ch;
                    job_next.cnt      = cnt_t'(1);
                end
                else
                begin
                    job_next.cnt = fill_app;
                end
                in_token_next = 1'b0;
                fill_next     = '0;
            end
            else if (text_last)
            begin
                job_next.cnt  = fill_app;
                in_token_next = 1'b0;
                fill_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg  <= 1'b0;
            fill_reg      <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_token_reg  <= in_token_next;
                fill_reg      <= fill_next;
                job_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok_next;
            job_reg <= job_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/xed_emitter.sv @@
// Result emitter: streams out each job's bytes in order and keeps the decoded length.
`default_nettype none
module xed_emitter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire xed_pkg::job_t job,
    output logic               job_take,
    output logic               out_valid,
    input  wire logic          out_ready,
    output xed_pkg::byte_t     out_byte,
    output logic               run_last,
    output logic               text_done,
    output xed_pkg::len_t      decoded_length
);
    import xed_pkg::*;

    logic active_reg;
    tok_t buf_reg;
    cnt_t cnt_reg;
    idx_t idx_reg;
    logic last_reg;
    len_t len_reg, len_next;
    logic final_byte;
    logic fire;

    assign final_byte     = ({1'b0, idx_reg} == {1'b0, cnt_reg} - 1'b1);
    assign fire           = active_reg && out_ready;
    assign job_take       = !active_reg || (out_ready && final_byte);
    assign out_valid      = active_reg;
    assign out_byte       = buf_reg[idx_reg];
    assign run_last       = final_byte;
    assign text_done      = final_byte && last_reg;
    assign decoded_length = (len_reg == '1) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        len_next = len_reg;
        if (fire)
            len_next = (final_byte && last_reg) ? '0 : decoded_length;
        // A request that releases nothing still ends its text.
        if (job_take && job_valid && job.cnt == '0 && job.last)
            len_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            last_reg   <= 1'b0;
            len_reg    <= '0;
        end
        else
        begin
            len_reg <= len_next;
            if (job_take)
            begin
                active_reg <= job_valid && (job.cnt != '0);
                cnt_reg    <= job.cnt;
                idx_reg    <= '0;
                last_reg   <= job.last;
            end
            else if (fire)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take && job_valid)
            buf_reg <= job.bytes;
    end
endmodule
`default_nettype wire

@@ hw/rtl/xml_entity_decoder.sv @@
// A request passes the collector's job register and then the emitter's buffer before
// its first result is offered. Throughput: one request per cycle while each releases
// at most one byte and out_ready stays high; a request that flushes an unmatched token
// holds the emitter until every one of its bytes has been taken.
// One job register between collector and emitter lets a request enter while a
// result waits. Reset clears the token state, the job and the length counter.
`default_nettype none
`include "xml_entity_decoder_macros.svh"
module xml_entity_decoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire xed_pkg::byte_t text_byte,
    input  wire logic          text_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output xed_pkg::byte_t     out_byte,
    output logic               run_last,
    output logic               text_done,
    output xed_pkg::len_t      decoded_length
);
    import xed_pkg::*;

    logic job_valid;
    job_t job;
    logic job_take;

    xed_collector u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .text_last (text_last),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    xed_emitter u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job            (job),
        .job_take       (job_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .text_done      (text_done),
        .decoded_length (decoded_length)
    );

    // Input stalls only while the output side is busy.
    `XED_ASSERT_SAME(a_stall_needs_output, !in_ready, out_valid)
    `XED_ASSERT_SAME(a_done_ends_run, out_valid && text_done, run_last)
    // Within a run the next byte follows at once; length counts up by one or saturates.
    `XED_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last,
        out_valid && (decoded_length == $past(decoded_length) + 1'b1 || decoded_length == '1))
endmodule
`default_nettype wire

@@ sim/xml_entity_decoder_tb.sv @@
// Self-checking testbench for the streaming XML entity decoder.
`default_nettype none
module xml_entity_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xed_pkg::*;

    localparam int RANDOM_ITEMS = 210;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_HOLD_CYCLES = 300;

    // Golden model of the decoder plus the queue of characters it expects to see.
    class decoded_text_checker;
        typedef struct {
            byte_t ch;
            logic  run_last;
            logic  done;
            len_t  length;
        } decoded_char_t;

        decoded_char_t expected_chars[$];
        bit    collecting = 1'b0;
        byte_t token[TOKEN_MAX];
        int    fill = 0;
        len_t  emitted = '0;
        int    errors = 0;

        function void put_char(byte_t b);
            decoded_char_t c;
            if (emitted != '1)
                emitted++;
            c.ch = b;
            c.run_last = 1'b0;
            c.done = 1'b0;
            c.length = emitted;
            expected_chars.push_back(c);
        endfunction

        function void flush_token();
            for (int i = 0; i < fill; i++)
                put_char(token[i]);
        endfunction

        function bit decode_entity(output byte_t ch);
            logic [47:0] w;
            w = '0;
            ch = '0;
            for (int i = 0; i < fill && i < 6; i++)
                w = {w[39:0], token[i]};
            case (fill)
                4:
                begin
                    if (w[31:0] == "&lt;")
                        ch = "<";
                    else if (w[31:0] == "&gt;")
                        ch = ">";
                    else
                        return 1'b0;
                end
                5:
                begin
                    if (w[39:0] == "&amp;")
                        ch = AMP;
                    else
                        return 1'b0;
                end
                6:
                begin
                    if (w == "&apos;")
                        ch = 8'h27;
                    else if (w == "&quot;")
                        ch = 8'h22;
                    else
                        return 1'b0;
                end
                default:
                    return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void note_request(byte_t b, logic last);
            int    first;
            byte_t ch;
            first = expected_chars.size();
            if (!collecting)
            begin
                if (b == AMP)
                begin
                    token[0] = b;
                    fill = 1;
                    collecting = 1'b1;
                    if (fill >= TOKEN_MAX || last)
                    begin
                        flush_token();
                        collecting = 1'b0;
                        fill = 0;
                    end
                end
                else
                    put_char(b);
            end
            else
            begin
                if (fill < TOKEN_MAX)
                begin
                    token[fill] = b;
                    fill++;
                end
                if (b == SEMI || fill >= TOKEN_MAX)
                begin
                    if (decode_entity(ch))
                        put_char(ch);
                    else
                        flush_token();
                    collecting = 1'b0;
                    fill = 0;
                end
                else if (last)
                begin
                    flush_token();
                    collecting = 1'b0;
                    fill = 0;
                end
            end
            if (expected_chars.size() > first)
            begin
                expected_chars[expected_chars.size()-1].run_last = 1'b1;
                expected_chars[expected_chars.size()-1].done = last;
            end
            // The end of a text closes any token and restarts the length count.
            if (last)
            begin
                collecting = 1'b0;
                fill = 0;
                emitted = '0;
            end
        endfunction

        function void check_result(byte_t b, logic rl, logic td, len_t length);
            decoded_char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected output byte, expected none, actual %h", $time, b);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (b !== want.ch)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, want.ch, b);
                errors++;
            end
            if (rl !== want.run_last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
                errors++;
            end
            if (td !== want.done)
            begin
                $display("%0t: text_done expected %b actual %b", $time, want.done, td);
                errors++;
            end
            if (length !== want.length)
            begin
                $display("%0t: decoded_length expected %0d actual %0d",
                         $time, want.length, length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    byte_t text_byte;
    logic  text_last;
    logic  out_valid;
    logic  out_ready;
    byte_t out_byte;
    logic  run_last;
    logic  text_done;
    len_t  decoded_length;

    decoded_text_checker board = new;
    bit idle_on = 1'b1;
    bit rx_hold_req = 1'b0;
    int sent = 0;

    xml_entity_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .text_last      (text_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .text_done      (text_done),
        .decoded_length (decoded_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold when the stimulus asks for it.
    initial
    begin : receiver
        int gap;
        int hold_left;
        gap = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                board.check_result(out_byte, run_last, text_done, decoded_length);
                gap = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_req(input byte_t b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        text_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(b, last);
        sent++;
    endtask

    task automatic send_text(input string s, input bit closes_text);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], closes_text && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic byte_t plain_byte();
        byte_t b;
        if ($urandom_range(0, 7) == 0)
            return SEMI;
        b = byte_t'($urandom_range(1, 255));
        return (b == AMP) ? 8'h41 : b;
    endfunction

    function automatic byte_t token_byte();
        string letters;
        letters = "ltgampsoqu";
        case ($urandom_range(0, 5))
            0: return SEMI;
            1: return AMP;
            2: return byte_t'($urandom_range(1, 255));
            default: return letters[$urandom_range(0, letters.len() - 1)];
        endcase
    endfunction

    function automatic string pick_entity();
        case ($urandom_range(0, 4))
            0: return "&lt;";
            1: return "&gt;";
            2: return "&amp;";
            3: return "&apos;";
            default: return "&quot;";
        endcase
    endfunction

    // One text built mostly from well-formed pieces, with broken tokens and noise mixed in.
    task automatic send_random_text();
        byte_t text_q[$];
        string s;
        int    pieces;
        int    kind;
        int    k;
        pieces = $urandom_range(1, 8);
        repeat (pieces)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                text_q.push_back(plain_byte());
            else if (kind < 7)
            begin
                s = pick_entity();
                for (int i = 0; i < s.len(); i++)
                    text_q.push_back(s[i]);
            end
            else if (kind < 9)
            begin
                text_q.push_back(AMP);
                k = $urandom_range(0, 7);
                repeat (k) text_q.push_back(token_byte());
            end
            else
            begin
                s = pick_entity();
                k = $urandom_range(1, s.len() - 1);
                for (int i = 0; i < k; i++)
                    text_q.push_back(s[i]);
                text_q.push_back(token_byte());
            end
        end
        foreach (text_q[i])
            send_req(text_q[i], i == text_q.size() - 1);
    endtask

    initial
    begin : stimulus
        int texts;
        texts = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = '0;
        text_last = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entity, a stray semicolon, a lone ampersand ending a text, a full token
        // holding a second ampersand, extreme byte values and an open token at end of text.
        send_text("&lt;&gt;&amp;&apos;&quot;", 1'b0);
        send_req(SEMI, 1'b0);
        send_text("&", 1'b1);
        send_text("&ab&cde", 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h01, 1'b0);
        send_text("&qu", 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            texts++;
            idle_on = ($urandom_range(0, 3) != 0);
            if (texts == 6)
            begin
                // Stall the output for a long time while long flushes keep arriving.
                idle_on = 1'b0;
                rx_hold_req = 1'b1;
                repeat (6) send_text("&xyzuvw", 1'b0);
                send_text("ok", 1'b1);
            end
            else if (texts == 12)
            begin
                wait_drained();
                send_random_text();
            end
            else
                send_random_text();
        end

        wait_drained();
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
